FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: design/bcsia_pkg.sv
// shared constants and types for the binned coordinate sort and id assign block
`timescale 1ns / 1ps
`default_nettype none

package bcsia_pkg;

  localparam int MAX_RECORDS_DEF = 1024;
  localparam int MAX_BINS_DEF    = 1024;
  localparam int COORD_BITS_DEF  = 32;

  localparam int BIN_IN_W    = 32;
  localparam int IN_COORD_W  = 32;
  localparam int OWNER_W     = 16;
  localparam int LOCAL_W     = 20;
  localparam int ID_W        = 48;
  localparam int STATUS_W    = 2;
  localparam int LOAD_POS_W  = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 48;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_RECORD  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_BIN = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_BIN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_BASE  = 2'd2;

  localparam logic [BIN_IN_W-1:0] BIN_HIGH_RESET = 32'd1024;

  // broadcast controls for every cell of the chain
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/bcsia_cell.sv
// one cell of the sorting chain: holds a record key and passes the larger one on
`timescale 1ns / 1ps
`default_nettype none

module bcsia_cell #(
  parameter int KEY_W = 106,
  parameter int POS_W = 10
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  bcsia_pkg::cell_ctrl_t   ctrl,
  input  wire                     up_valid,
  input  wire  [KEY_W-1:0]        up_key,
  input  wire  [POS_W-1:0]        up_pos,
  input  wire                     right_valid,
  input  wire  [KEY_W-1:0]        right_key,
  input  wire  [POS_W-1:0]        right_pos,
  output logic                    trav_valid,
  output logic [KEY_W-1:0]        trav_key,
  output logic [POS_W-1:0]        trav_pos,
  output logic                    held_valid,
  output logic [KEY_W-1:0]        held_key,
  output logic [POS_W-1:0]        held_pos
);

  logic             held_valid_r, held_valid_nxt;
  logic [KEY_W-1:0] held_key_r, held_key_nxt;
  logic [POS_W-1:0] held_pos_r, held_pos_nxt;
  logic             trav_valid_r, trav_valid_nxt;
  logic [KEY_W-1:0] trav_key_r, trav_key_nxt;
  logic [POS_W-1:0] trav_pos_r, trav_pos_nxt;

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_key_nxt   = held_key_r;
    held_pos_nxt   = held_pos_r;
    trav_valid_nxt = 1'b0;
    trav_key_nxt   = trav_key_r;
    trav_pos_nxt   = trav_pos_r;
    if (ctrl.clear) begin
      held_valid_nxt = 1'b0;
    end else if (ctrl.shift) begin
      held_valid_nxt = right_valid;
      held_key_nxt   = right_key;
      held_pos_nxt   = right_pos;
    end else if (up_valid) begin
      if (!held_valid_r) begin
        held_valid_nxt = 1'b1;
        held_key_nxt   = up_key;
        held_pos_nxt   = up_pos;
      end else if ((up_key < held_key_r) ||
                   ((up_key == held_key_r) && (up_pos < held_pos_r))) begin
        // smaller key takes the slot; equal keys are ordered by load slot,
        // so the older of two equal records stays ahead of the younger one
        held_key_nxt   = up_key;
        held_pos_nxt   = up_pos;
        trav_valid_nxt = 1'b1;
        trav_key_nxt   = held_key_r;
        trav_pos_nxt   = held_pos_r;
      end else begin
        trav_valid_nxt = 1'b1;
        trav_key_nxt   = up_key;
        trav_pos_nxt   = up_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      trav_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      trav_valid_r <= trav_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_key_r <= held_key_nxt;
    held_pos_r <= held_pos_nxt;
    trav_key_r <= trav_key_nxt;
    trav_pos_r <= trav_pos_nxt;
  end

  assign trav_valid = trav_valid_r;
  assign trav_key   = trav_key_r;
  assign trav_pos   = trav_pos_r;
  assign held_valid = held_valid_r;
  assign held_key   = held_key_r;
  assign held_pos   = held_pos_r;

endmodule

`default_nettype wire

FILE: design/binned_coordinate_sort_id_assign.sv
// top level: record store, systolic sort chain and sorted id assignment
// usage:
//   input channel (in_valid / in_stall) carries one word per item: op 0 loads a
//   record, op 1 fetches the next result. result channel (out_valid / out_stall)
//   carries one word per fetch and none per load.
//   loads are taken one per cycle unless a result is held; each record enters
//   the head of a chain of MAX_RECORDS cells and ripples one cell per cycle to
//   its sorted place. the first fetch of a non-empty good batch waits while the
//   chain settles, stalled through a settle phase counted down from record_count.
//   after that fetches are taken one per cycle unless the receiver stalls: the
//   chain shifts toward its head each fetch and the payload store is read at
//   the head's load slot. a result is registered when its fetch is accepted.
//   a batch-done fetch clears the store; a bad bin makes every fetch report
//   an error until reset.
//   when the receiver stalls, the result register holds and the input stalls
//   until the word is taken.
//   reset (rst_n low, synchronous) empties the store and chain, clears the
//   error flag and sets bin_low = 0, bin_high = 1024, id_base = 0.
//   configuration is written through cfg_we / cfg_index / cfg_data while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module binned_coordinate_sort_id_assign #(
  parameter int MAX_RECORDS = bcsia_pkg::MAX_RECORDS_DEF,
  parameter int MAX_BINS    = bcsia_pkg::MAX_BINS_DEF,
  parameter int COORD_BITS  = bcsia_pkg::COORD_BITS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // input channel
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire                                     in_op,
  input  wire  [bcsia_pkg::BIN_IN_W-1:0]          in_bin_number,
  input  wire  signed [bcsia_pkg::IN_COORD_W-1:0] in_coord_x,
  input  wire  signed [bcsia_pkg::IN_COORD_W-1:0] in_coord_y,
  input  wire  signed [bcsia_pkg::IN_COORD_W-1:0] in_coord_z,
  input  wire  [bcsia_pkg::OWNER_W-1:0]           in_owner_proc,
  input  wire  [bcsia_pkg::LOCAL_W-1:0]           in_local_index,
  // result channel
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic [bcsia_pkg::STATUS_W-1:0]          out_status,
  output logic [bcsia_pkg::ID_W-1:0]              out_new_id,
  output logic [bcsia_pkg::LOAD_POS_W-1:0]        out_load_position,
  output logic [bcsia_pkg::OWNER_W-1:0]           out_dest_proc,
  output logic [bcsia_pkg::LOCAL_W-1:0]           out_dest_index,
  output logic                                    out_last_result,
  // configuration port
  input  wire                                     cfg_we,
  input  wire  [bcsia_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [bcsia_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int POS_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = POS_W + 1;
  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int KEY_W = BIN_W + 3 * COORD_BITS;
  localparam int PAY_W = bcsia_pkg::OWNER_W + bcsia_pkg::LOCAL_W;
  localparam int BIN_IN_W = bcsia_pkg::BIN_IN_W;
  localparam int ID_W = bcsia_pkg::ID_W;
  localparam int LP_W = bcsia_pkg::LOAD_POS_W;

  localparam logic [COORD_BITS-1:0] SIGN_FLIP = {1'b1, {(COORD_BITS-1){1'b0}}};

  // batch phases
  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SETTLE = 2'd1;
  localparam logic [1:0] ST_FETCH  = 2'd2;

  // configuration registers
  logic [BIN_IN_W-1:0] bin_low_r;
  logic [BIN_IN_W-1:0] bin_high_r;
  logic [ID_W-1:0]     id_base_r;

  // control state
  logic [1:0]     state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] fetch_ptr_r, fetch_ptr_nxt;
  logic [CNT_W-1:0] settle_cnt_r, settle_cnt_nxt;
  logic           bad_r, bad_nxt;

  // handshake decode
  logic accept, is_fetch, need_sort, out_block;
  logic load_go, fetch_go, rec_go, done_go;
  logic store_full;
  logic [bcsia_pkg::STATUS_W-1:0] status_sel;

  // key forming
  logic [63:0]          x_ext, y_ext, z_ext;
  logic [COORD_BITS-1:0] x_key, y_key, z_key;
  logic [BIN_IN_W-1:0]  rel_full;
  logic                 bin_bad;
  logic [BIN_W-1:0]     rel_bin;
  logic [KEY_W-1:0]     new_key;

  // chain wiring: trav index 0 feeds cell 0, trav index i+1 is the output of cell i, held index i is cell i
  logic [MAX_RECORDS:0] trav_valid;
  logic [KEY_W-1:0]     trav_key [0:MAX_RECORDS];
  logic [POS_W-1:0]     trav_pos [0:MAX_RECORDS];
  logic [MAX_RECORDS:0] held_valid;
  logic [KEY_W-1:0]     held_key [0:MAX_RECORDS];
  logic [POS_W-1:0]     held_pos [0:MAX_RECORDS];
  bcsia_pkg::cell_ctrl_t cell_ctrl;

  // payload store indexed by load slot
  logic [PAY_W-1:0] pay_mem [0:MAX_RECORDS-1];
  logic [PAY_W-1:0] pay_rd_r;

  // result register
  logic                            out_valid_r;
  logic [bcsia_pkg::STATUS_W-1:0]  out_status_r;
  logic [ID_W-1:0]                 out_new_id_r;
  logic [LP_W-1:0]                 out_pos_r;
  logic                            out_last_r;
  logic                            out_rec;

  logic [ID_W-1:0]       id_nxt;
  logic [CNT_W-1:0]      fetch_ptr_inc;
  logic [POS_W+LP_W-1:0] head_pos_ext;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_low_r  <= '0;
      bin_high_r <= bcsia_pkg::BIN_HIGH_RESET;
      id_base_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcsia_pkg::CFG_BIN_LOW:  bin_low_r  <= cfg_data[BIN_IN_W-1:0];
        bcsia_pkg::CFG_BIN_HIGH: bin_high_r <= cfg_data[BIN_IN_W-1:0];
        bcsia_pkg::CFG_ID_BASE:  id_base_r  <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sort key: relative bin, then x, y, z with sign bit flipped so that an
  // unsigned compare of the concatenation gives the lexicographic order
  // ---------------------------------------------------------------------------
  assign x_ext = {{32{in_coord_x[31]}}, in_coord_x};
  assign y_ext = {{32{in_coord_y[31]}}, in_coord_y};
  assign z_ext = {{32{in_coord_z[31]}}, in_coord_z};
  assign x_key = x_ext[COORD_BITS-1:0] ^ SIGN_FLIP;
  assign y_key = y_ext[COORD_BITS-1:0] ^ SIGN_FLIP;
  assign z_key = z_ext[COORD_BITS-1:0] ^ SIGN_FLIP;

  assign rel_full = in_bin_number - bin_low_r;
  assign bin_bad  = (in_bin_number < bin_low_r) || (in_bin_number >= bin_high_r) ||
                    (rel_full >= BIN_IN_W'(MAX_BINS));
  // a bad bin still gets stored, at relative bin zero
  assign rel_bin  = bin_bad ? '0 : rel_full[BIN_W-1:0];
  assign new_key  = {rel_bin, x_key, y_key, z_key};

  // ---------------------------------------------------------------------------
  // handshake and phase control
  // ---------------------------------------------------------------------------
  assign is_fetch   = (in_op == bcsia_pkg::OP_FETCH);
  assign out_block  = out_valid_r && out_stall;
  // first fetch of a non-empty good batch holds until the chain has settled
  assign need_sort  = in_valid && is_fetch && (state_r == ST_LOAD) && !bad_r &&
                      (count_r != '0);
  assign in_stall   = (state_r == ST_SETTLE) || need_sort || out_block;
  assign accept     = in_valid && !in_stall;

  assign store_full = (count_r == CNT_W'(MAX_RECORDS));
  // loads in the fetch phase or into a full store are dropped
  assign load_go    = accept && !is_fetch && (state_r == ST_LOAD) && !store_full;
  assign fetch_go   = accept && is_fetch;

  always_comb begin
    if (bad_r) begin
      status_sel = bcsia_pkg::STATUS_BAD_BIN;
    end else if (fetch_ptr_r >= count_r) begin
      status_sel = bcsia_pkg::STATUS_DONE;
    end else begin
      status_sel = bcsia_pkg::STATUS_RECORD;
    end
  end

  assign rec_go  = fetch_go && (status_sel == bcsia_pkg::STATUS_RECORD);
  assign done_go = fetch_go && (status_sel == bcsia_pkg::STATUS_DONE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    fetch_ptr_nxt  = fetch_ptr_r;
    settle_cnt_nxt = settle_cnt_r;
    bad_nxt        = bad_r;
    if (load_go) begin
      count_nxt = count_r + CNT_W'(1);
      if (bin_bad) begin
        bad_nxt = 1'b1;
      end
    end
    case (state_r)
      ST_LOAD: begin
        if (need_sort) begin
          state_nxt      = ST_SETTLE;
          settle_cnt_nxt = count_r;
        end
      end
      ST_SETTLE: begin
        // count down from record_count so that every ripple has ended
        if (settle_cnt_r == '0) begin
          state_nxt = ST_FETCH;
        end else begin
          settle_cnt_nxt = settle_cnt_r - CNT_W'(1);
        end
      end
      ST_FETCH: begin
        if (rec_go) begin
          fetch_ptr_nxt = fetch_ptr_inc;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    if (done_go) begin
      state_nxt     = ST_LOAD;
      count_nxt     = '0;
      fetch_ptr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      fetch_ptr_r  <= '0;
      settle_cnt_r <= '0;
      bad_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      fetch_ptr_r  <= fetch_ptr_nxt;
      settle_cnt_r <= settle_cnt_nxt;
      bad_r        <= bad_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // sorting chain: loads enter cell 0, record fetches shift everything toward cell 0
  // ---------------------------------------------------------------------------
  assign cell_ctrl.shift = rec_go;
  assign cell_ctrl.clear = done_go;

  assign trav_valid[0] = load_go;
  assign trav_key[0]   = new_key;
  assign trav_pos[0]   = count_r[POS_W-1:0];

  // past the tail of the chain reads as empty
  assign held_valid[MAX_RECORDS] = 1'b0;
  assign held_key[MAX_RECORDS]   = '0;
  assign held_pos[MAX_RECORDS]   = '0;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    bcsia_cell #(
      .KEY_W (KEY_W),
      .POS_W (POS_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl),
      .up_valid    (trav_valid[i]),
      .up_key      (trav_key[i]),
      .up_pos      (trav_pos[i]),
      .right_valid (held_valid[i+1]),
      .right_key   (held_key[i+1]),
      .right_pos   (held_pos[i+1]),
      .trav_valid  (trav_valid[i+1]),
      .trav_key    (trav_key[i+1]),
      .trav_pos    (trav_pos[i+1]),
      .held_valid  (held_valid[i]),
      .held_key    (held_key[i]),
      .held_pos    (held_pos[i])
    );
  end

  // ---------------------------------------------------------------------------
  // payload store: written at the load slot, read at the chain head's slot
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load_go) begin
      pay_mem[count_r[POS_W-1:0]] <= {in_owner_proc, in_local_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rec_go) begin
      pay_rd_r <= pay_mem[held_pos[0]];
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  assign fetch_ptr_inc = fetch_ptr_r + CNT_W'(1);
  assign id_nxt        = id_base_r + ID_W'(1) + ID_W'(fetch_ptr_r);
  assign head_pos_ext  = {{LP_W{1'b0}}, held_pos[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fetch_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_go) begin
      out_status_r <= status_sel;
      if (rec_go) begin
        out_new_id_r <= id_nxt;
        out_pos_r    <= head_pos_ext[LP_W-1:0];
        out_last_r   <= (fetch_ptr_inc == count_r);
      end else begin
        out_new_id_r <= '0;
        out_pos_r    <= '0;
        out_last_r   <= 1'b0;
      end
    end
  end

  assign out_rec           = (out_status_r == bcsia_pkg::STATUS_RECORD);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_new_id        = out_new_id_r;
  assign out_load_position = out_pos_r;
  assign out_last_result   = out_last_r;
  assign out_dest_proc     = out_rec ? pay_rd_r[PAY_W-1 -: bcsia_pkg::OWNER_W] : '0;
  assign out_dest_index    = out_rec ? pay_rd_r[bcsia_pkg::LOCAL_W-1:0] : '0;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // while records remain to be fetched the chain head holds one
  `ASSERT_IMP(a_head_valid, clk, rst_n, ((state_r == ST_FETCH) && (fetch_ptr_r < count_r)), held_valid[0])
  // no record is still rippling once fetching has begun
  `ASSERT_IMP(a_chain_settled, clk, rst_n, (state_r == ST_FETCH), (trav_valid == '0))
  // each stored load advances the record count by one
  `ASSERT_NEXT(a_load_count, clk, rst_n, load_go, (count_r == $past(count_r) + 1'b1))

endmodule

`default_nettype wire

FILE: tb/sv/tb_binned_coordinate_sort_id_assign.sv
// self-checking testbench for the binned coordinate sort and sorted id assign block
`timescale 1ns / 1ps

import bcsia_pkg::*;

// one word on the input channel
typedef struct packed {
  logic                  op;
  logic [BIN_IN_W-1:0]   bin;
  logic [IN_COORD_W-1:0] x;
  logic [IN_COORD_W-1:0] y;
  logic [IN_COORD_W-1:0] z;
  logic [OWNER_W-1:0]    owner;
  logic [LOCAL_W-1:0]    local_index;
} in_word_t;

// one word on the result channel
typedef struct packed {
  logic [STATUS_W-1:0]   status;
  logic [ID_W-1:0]       new_id;
  logic [LOAD_POS_W-1:0] load_pos;
  logic [OWNER_W-1:0]    dest_proc;
  logic [LOCAL_W-1:0]    dest_index;
  logic                  last_result;
} result_t;

// record store, stable sort and id numbering, plus the queue of fetch answers
class id_order_board;
  bit [31:0]         bin_low;
  bit [31:0]         bin_high;
  bit [ID_W-1:0]     id_base;
  bit [9:0]          held_bin[MAX_RECORDS_DEF];
  bit [31:0]         held_x[MAX_RECORDS_DEF];
  bit [31:0]         held_y[MAX_RECORDS_DEF];
  bit [31:0]         held_z[MAX_RECORDS_DEF];
  bit [OWNER_W-1:0]  held_owner[MAX_RECORDS_DEF];
  bit [LOCAL_W-1:0]  held_local[MAX_RECORDS_DEF];
  bit [9:0]          rank_to_slot[MAX_RECORDS_DEF];
  int unsigned       stored;
  int unsigned       served;
  bit                ordered;
  bit                poisoned;
  result_t           due_results[$];
  int unsigned       errors;
  int unsigned       checked;
  int unsigned       words_used;
  int unsigned       loads_kept;
  int unsigned       records_out;
  int unsigned       batch_ends;
  int unsigned       bad_words;

  function new();
    bin_low  = '0;
    bin_high = BIN_HIGH_RESET;
    id_base  = '0;
  endfunction

  function void note_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BIN_LOW:  bin_low  = data[31:0];
      CFG_BIN_HIGH: bin_high = data[31:0];
      CFG_ID_BASE:  id_base  = data[ID_W-1:0];
      default: ;
    endcase
  endfunction

  // bin first, then x, y, z with sign bits flipped so unsigned order is signed order
  function bit [105:0] sort_key(bit [9:0] s);
    return {held_bin[s], held_x[s], held_y[s], held_z[s]};
  endfunction

  // insertion sort on strict greater-than, so equal keys stay in load order
  function void order_store();
    bit [9:0] cur;
    int       j;
    for (int i = 0; i < int'(stored); i++) rank_to_slot[i] = 10'(i);
    for (int i = 1; i < int'(stored); i++) begin
      cur = rank_to_slot[i];
      j = i;
      while (j > 0 && sort_key(rank_to_slot[j-1]) > sort_key(cur)) begin
        rank_to_slot[j] = rank_to_slot[j-1];
        j--;
      end
      rank_to_slot[j] = cur;
    end
    ordered = 1'b1;
  endfunction

  function void note_in_word(in_word_t w);
    bit [31:0] rel;
    bit [9:0]  s;
    result_t   r;
    if (w.op == OP_LOAD) begin
      // loads are dropped once fetching started or the store is full
      if (ordered || stored >= MAX_RECORDS_DEF) return;
      rel = w.bin - bin_low;
      if (w.bin < bin_low || w.bin >= bin_high || rel >= MAX_BINS_DEF) begin
        poisoned = 1'b1;
        rel = '0;
      end
      s = 10'(stored);
      held_bin[s]   = rel[9:0];
      held_x[s]     = w.x ^ 32'h8000_0000;
      held_y[s]     = w.y ^ 32'h8000_0000;
      held_z[s]     = w.z ^ 32'h8000_0000;
      held_owner[s] = w.owner;
      held_local[s] = w.local_index;
      stored++;
      loads_kept++;
      words_used++;
      return;
    end
    r = '0;
    words_used++;
    if (poisoned) begin
      r.status = STATUS_BAD_BIN;
      bad_words++;
    end else if (served >= stored) begin
      r.status = STATUS_DONE;
      stored   = 0;
      served   = 0;
      ordered  = 1'b0;
      batch_ends++;
    end else begin
      if (!ordered) order_store();
      s = rank_to_slot[served];
      r.status      = STATUS_RECORD;
      r.new_id      = id_base + 48'd1 + 48'(served);
      r.load_pos    = s;
      r.dest_proc   = held_owner[s];
      r.dest_index  = held_local[s];
      r.last_result = (served + 1 == stored);
      served++;
      records_out++;
    end
    due_results.push_back(r);
  endfunction

  task report(string what, logic [63:0] got_v, logic [63:0] want_v);
    errors++;
    if (errors <= 30)
      $display("result %0d: %s is %0h, should be %0h", checked, what, got_v, want_v);
  endtask

  task check_out_word(result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      report("unrequested word, status", 64'(got.status), 64'(0));
      return;
    end
    want = due_results.pop_front();
    if (got.status != want.status)
      report("status", 64'(got.status), 64'(want.status));
    if (got.new_id != want.new_id)
      report("new_id", 64'(got.new_id), 64'(want.new_id));
    if (got.load_pos != want.load_pos)
      report("load_position", 64'(got.load_pos), 64'(want.load_pos));
    if (got.dest_proc != want.dest_proc)
      report("dest_proc", 64'(got.dest_proc), 64'(want.dest_proc));
    if (got.dest_index != want.dest_index)
      report("dest_index", 64'(got.dest_index), 64'(want.dest_index));
    if (got.last_result != want.last_result)
      report("last_result", 64'(got.last_result), 64'(want.last_result));
    checked++;
  endtask
endclass

module tb_binned_coordinate_sort_id_assign;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;
  // the chain ripple can keep the block busy after the last result
  localparam int unsigned SETTLE_CYCLES = MAX_RECORDS_DEF + 16;
  localparam int unsigned ROUND_WORDS   = 65;
  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;

  typedef enum int {
    BAD_EMPTY_RANGE,
    BAD_BELOW_LOW,
    BAD_AT_HIGH,
    BAD_PAST_BINS
  } bad_case_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_word_t in_word  = '0;

  // result channel
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ID_W-1:0]       out_new_id;
  logic [LOAD_POS_W-1:0] out_load_position;
  logic [OWNER_W-1:0]    out_dest_proc;
  logic [LOCAL_W-1:0]    out_dest_index;
  logic                  out_last_result;

  // configuration port
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  id_order_board board = new();

  // idle rates per side, in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // long receiver hold-off, requested by the main flow and counted below
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;

  int unsigned cycle_count   = 0;
  int unsigned settings_used = 0;

  always #10 clk = ~clk;

  binned_coordinate_sort_id_assign u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_word.op),
    .in_bin_number     (in_word.bin),
    .in_coord_x        (in_word.x),
    .in_coord_y        (in_word.y),
    .in_coord_z        (in_word.z),
    .in_owner_proc     (in_word.owner),
    .in_local_index    (in_word.local_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_new_id        (out_new_id),
    .out_load_position (out_load_position),
    .out_dest_proc     (out_dest_proc),
    .out_dest_index    (out_dest_index),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // result side: every taken word is checked against the oldest open fetch
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_out_word({out_status, out_new_id, out_load_position,
                            out_dest_proc, out_dest_index, out_last_result});
  end

  // receiver stall, changed on the falling edge; a hold-off overrides the random rate
  always @(negedge clk) begin : recv_side
    bit stall_next;
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else begin
      stall_next = ($urandom_range(99) < recv_idle_pct);
    end
    out_stall <= stall_next;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still open",
               cycle_count, board.due_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // bins inside the owned range, often at its edges or in a small set for ties
  function automatic logic [31:0] pick_bin();
    logic [31:0] span;
    span = board.bin_high - board.bin_low;
    if (span > MAX_BINS_DEF) span = MAX_BINS_DEF;
    if (span == 0) span = 1;
    case ($urandom_range(3))
      0: return board.bin_low;
      1: return board.bin_low + span - 1;
      2: return board.bin_low + ($urandom_range(3) % span);
      default: return board.bin_low + $urandom_range(span - 1);
    endcase
  endfunction

  // coordinates: extremes, values near zero for ties, and full random
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(2)) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_word_t record_word(logic [31:0] bin, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z,
                                           logic [OWNER_W-1:0] owner,
                                           logic [LOCAL_W-1:0] lidx);
    in_word_t w;
    w.op          = OP_LOAD;
    w.bin         = bin;
    w.x           = x;
    w.y           = y;
    w.z           = z;
    w.owner       = owner;
    w.local_index = lidx;
    return w;
  endfunction

  function automatic in_word_t load_word();
    return record_word(pick_bin(), pick_coord(), pick_coord(), pick_coord(),
                       16'($urandom()), 20'($urandom()));
  endfunction

  // a fetch carries junk in every field but op
  function automatic in_word_t fetch_word();
    in_word_t w;
    w    = load_word();
    w.op = OP_FETCH;
    return w;
  endfunction

  // drive one word on the falling edge, hold it until taken
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_in_word(w);
  endtask

  // drop valid, wait for every open fetch, then let the chain settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.note_reg(idx, data);
  endtask

  // all three registers plus a write to the empty index; junk in unused upper bits
  task automatic set_regs(input logic [31:0] lo, input logic [31:0] hi,
                          input logic [ID_W-1:0] base);
    wait_idle();
    write_reg(CFG_BIN_LOW, {16'($urandom()), lo});
    write_reg(CFG_NO_REG, {$urandom(), 16'($urandom())});
    write_reg(CFG_BIN_HIGH, {16'($urandom()), hi});
    write_reg(CFG_ID_BASE, base);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // one batch: loads, then fetches until the batch-done word, with some noise
  // (an early fetch that closes the load phase, loads dropped while fetching)
  task automatic run_batch(input int unsigned n, input bit may_break);
    int unsigned ends_before;
    for (int unsigned i = 0; i < n; i++) begin
      if (may_break && $urandom_range(39) == 0) send_word(fetch_word());
      send_word(load_word());
    end
    ends_before = board.batch_ends;
    while (board.batch_ends == ends_before) begin
      if ($urandom_range(9) == 0) send_word(load_word());
      else send_word(fetch_word());
    end
  endtask

  initial begin : main_flow
    int unsigned round_start;
    int unsigned batch_size;
    logic [31:0] lo;
    logic [31:0] bad_bin;
    bad_case_t   bad_pick;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with the reset range and id base zero
    send_idle_pct = 29;
    recv_idle_pct = 78;
    set_regs(32'd0, BIN_HIGH_RESET, 48'd0);

    // fetch into an empty store gives batch done
    send_word(fetch_word());
    // extremes of every field; equal keys to check the order is stable
    send_word(record_word(32'd5, 32'd0, 32'd0, 32'd0, 16'hFFFF, 20'hFFFFF));
    send_word(record_word(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 20'd0));
    send_word(record_word(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1, 20'd1));
    send_word(record_word(32'd1023, 32'd0, 32'd0, 32'd0, 16'd2, 20'd2));
    send_word(record_word(32'd5, 32'd0, 32'd0, 32'd0, 16'd3, 20'd3));
    send_word(record_word(32'd5, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'd4, 20'd4));
    send_word(record_word(32'd5, 32'd0, 32'd1, 32'd0, 16'd5, 20'd5));
    send_word(record_word(32'd5, 32'hFFFF_FFFF, 32'd9, 32'd9, 16'd6, 20'd6));
    send_word(fetch_word());
    send_word(fetch_word());
    // loads during the fetch phase are dropped, a bad bin there too
    send_word(record_word(32'd2000, 32'd0, 32'd0, 32'd0, 16'd7, 20'd7));
    send_word(record_word(32'd3, 32'd0, 32'd0, 32'd0, 16'd8, 20'd8));
    repeat (7) send_word(fetch_word());

    // random part: two settings per idle pattern
    for (int round = 0; round < 6; round++) begin
      case (round / 2)
        0: begin send_idle_pct = 29; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (round)
        0: set_regs(32'd0, 32'hFFFF_FFFF, {16'($urandom()), $urandom()});
        // top of the bin space, ids wrap inside the batch
        1: set_regs(32'hFFFF_FC00, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFC);
        2: begin
          lo = 32'($urandom_range(32'h7FFF_FFFF));
          set_regs(lo, lo + 32'($urandom_range(1, 1024)), {16'($urandom()), $urandom()});
        end
        // one bin only, first id wraps to zero
        3: set_regs(32'd0, 32'd1, 48'hFFFF_FFFF_FFFF);
        4: set_regs(32'd7, 32'd12, {16'($urandom()), $urandom()});
        default: set_regs(32'd0, BIN_HIGH_RESET, 48'd0);
      endcase
      // receiver holds off while fetches keep coming, so the input backs up
      if (round == 4) begin
        hold_request = 1'b1;
        run_batch(12, 1'b0);
      end
      // fill the store to the last slot; the extra loads are dropped
      if (round == 5) run_batch(MAX_RECORDS_DEF + 3, 1'b0);
      round_start = board.words_used;
      while (board.words_used - round_start < ROUND_WORDS) begin
        if ($urandom_range(9) == 0) batch_size = $urandom_range(17, 64);
        else batch_size = $urandom_range(0, 16);
        run_batch(batch_size, 1'b1);
      end
    end

    // closing step: a bad bin poisons the batch until reset, so it comes last
    bad_pick = bad_case_t'($urandom_range(3));
    case (bad_pick)
      BAD_EMPTY_RANGE: begin
        set_regs(32'hFFFF_FFFF, 32'd0, 48'd0);
        bad_bin = $urandom();
      end
      BAD_BELOW_LOW: begin
        set_regs(32'd100, 32'd200, 48'd0);
        bad_bin = $urandom_range(99);
      end
      BAD_AT_HIGH: begin
        set_regs(32'd0, BIN_HIGH_RESET, 48'd0);
        bad_bin = $urandom_range(1) ? BIN_HIGH_RESET : 32'hFFFF_FFFF;
      end
      default: begin
        set_regs(32'd0, 32'hFFFF_FFFF, 48'd0);
        bad_bin = 32'd1024 + $urandom_range(5000);
      end
    endcase
    send_word(load_word());
    send_word(record_word(bad_bin, pick_coord(), pick_coord(), pick_coord(),
                          16'($urandom()), 20'($urandom())));
    send_word(load_word());
    repeat (3) send_word(fetch_word());
    send_word(load_word());
    repeat (2) send_word(fetch_word());

    wait_idle();

    $display("covered %0d kept loads, %0d sorted records, %0d batch ends, %0d error words",
             board.loads_kept, board.records_out, board.batch_ends, board.bad_words);
    $display("over %0d register settings, bad bin case %0d, %0d results checked",
             settings_used, bad_pick, board.checked);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: binned_coordinate_sort_id_assign.f
+incdir+design
design/bcsia_pkg.sv
design/bcsia_cell.sv
design/binned_coordinate_sort_id_assign.sv
tb/sv/tb_binned_coordinate_sort_id_assign.sv
